FILE: rtl/pmsd_pkg.sv
// Shared types and constants for the point mean and sample stddev unit.
package pmsd_pkg;
	localparam int unsigned CoordW = 24;
	localparam int unsigned StdW   = 25;
	localparam int unsigned AccW   = 64;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_DIV_INIT,
		ST_DIV,
		ST_DEV_RD,
		ST_DEV_WAIT,
		ST_DEV_MUL,
		ST_DEV_ACC,
		ST_VDIV_INIT,
		ST_VDIV,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_NEXT_AXIS,
		ST_OUT
	} state_t;
endpackage

FILE: rtl/point_mean_sample_stddev_unit.sv
// Point mean and sample standard deviation unit, top level.
// Points (Q16.8) stream in at one per cycle while the unit is in its load state; up to
// MAX_POINTS of them are stored in an on-chip memory while running sums build. On a request
// marked tlast the unit stops accepting and runs one shared shift-subtract unit: a restoring
// divide for each mean (64 steps), a second pass over the store through the read, wait,
// multiply and accumulate states for each point and axis and, for sets of two or more points,
// a divide of each accumulator by n-1 (64 steps) and a bit-pair square root (32 steps). The
// result waits in an output register while the next set loads; a second result is held back
// in the sequencer, and no new point is taken, until the first one has been delivered.
module point_mean_sample_stddev_unit
	import pmsd_pkg::*;
#(
	parameter int unsigned MAX_POINTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // point_x[23:0], point_y[47:24]
	input  logic        s_tlast,   // last_point
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [103:0] m_tdata,  // mean_x, mean_y, std_x, std_y, zero fill
	output logic [1:0]  m_tuser    // stddev_valid, overflowed
);
	localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned CW = $clog2(MAX_POINTS + 1);

	state_t state_q, state_d;

	logic               abs_q;
	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      idx_q;
	logic               axis_q;
	logic               ovf_q;
	logic signed [CW+CoordW-1:0] sum_x_q, sum_y_q;
	logic signed [CoordW-1:0]    mean_x_q, mean_y_q;
	logic [AccW-1:0]    acc_x_q, acc_y_q;
	logic [StdW-1:0]    std_x_q, std_y_q;
	logic [47:0]        mem [MAX_POINTS];
	logic [47:0]        rd_q;
	logic signed [CoordW:0] dev_q;
	logic [2*CoordW+1:0]    sq_q;

	// shared shift-subtract unit
	logic [AccW-1:0] num_q, quo_q, rem_q, den_q, bit_q;
	logic [6:0]      step_q;
	logic            neg_q;

	logic out_v_q;
	logic [103:0] out_d_q;
	logic [1:0]   out_u_q;

	function automatic logic signed [CoordW-1:0] take(input logic [CoordW-1:0] r, input logic a);
		logic signed [CoordW-1:0] v;
		v = r;
		if (a && v[CoordW-1])
			v = (v == {1'b1, {(CoordW-1){1'b0}}}) ? {1'b0, {(CoordW-1){1'b1}}} : -v;
		return v;
	endfunction

	logic signed [CoordW-1:0] in_x, in_y;
	assign in_x = take(s_tdata[23:0], abs_q);
	assign in_y = take(s_tdata[47:24], abs_q);

	logic accept;
	assign s_tready  = (state_q == ST_LOAD);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_v_q;
	assign m_tdata   = out_d_q;
	assign m_tuser   = out_u_q;

	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!out_v_q || m_tready);

	logic full;
	assign full = (cnt_q == CW'(MAX_POINTS));

	logic [AccW:0] rem_sh;
	assign rem_sh = {rem_q, num_q[AccW-1]};
	logic [AccW-1:0] sq_try;
	assign sq_try = quo_q + bit_q;

	logic [CoordW-1:0]   dev_mag;
	logic [2*CoordW-1:0] dev_sq;
	assign dev_mag = dev_q[CoordW] ? CoordW'(-dev_q) : dev_q[CoordW-1:0];
	assign dev_sq  = dev_mag * dev_mag;

	logic signed [CW+CoordW-1:0] sum_sel;
	assign sum_sel = axis_q ? sum_y_q : sum_x_q;
	logic signed [CoordW-1:0] mean_sel;
	assign mean_sel = axis_q ? mean_y_q : mean_x_q;
	logic [AccW-1:0] acc_sel;
	assign acc_sel = axis_q ? acc_y_q : acc_x_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:      if (accept && s_tlast) state_d = ST_DIV_INIT;
			ST_DIV_INIT:  state_d = ST_DIV;
			ST_DIV:       if (step_q == 7'd63) state_d = axis_q ? ST_DEV_RD : ST_DIV_INIT;
			ST_DEV_RD:    state_d = ST_DEV_WAIT;
			ST_DEV_WAIT:  state_d = ST_DEV_MUL;
			ST_DEV_MUL:   state_d = ST_DEV_ACC;
			ST_DEV_ACC: begin
				if (!axis_q || CW'(idx_q) + CW'(1) < cnt_q) state_d = ST_DEV_RD;
				else if (cnt_q < CW'(2)) state_d = ST_OUT;
				else state_d = ST_VDIV_INIT;
			end
			ST_VDIV_INIT: state_d = ST_VDIV;
			ST_VDIV:      if (step_q == 7'd63) state_d = ST_SQRT_INIT;
			ST_SQRT_INIT: state_d = ST_SQRT;
			ST_SQRT:      if (step_q == 7'd31) state_d = ST_NEXT_AXIS;
			ST_NEXT_AXIS: state_d = axis_q ? ST_OUT : ST_VDIV_INIT;
			ST_OUT:       if (out_load) state_d = ST_LOAD;
			default:      state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && !full)
			mem[cnt_q[AW-1:0]] <= {in_y, in_x};
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			abs_q   <= 1'b0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			idx_q   <= '0;
			axis_q  <= 1'b0;
			step_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) abs_q <= cfg_data;
			if (out_load) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					axis_q <= 1'b0;
					if (accept) begin
						if (full) ovf_q <= 1'b1;
						else begin
							cnt_q   <= cnt_q + CW'(1);
							sum_x_q <= sum_x_q + (CW+CoordW)'(in_x);
							sum_y_q <= sum_y_q + (CW+CoordW)'(in_y);
						end
					end
				end
				ST_DIV_INIT: begin
					neg_q  <= sum_sel[CW+CoordW-1];
					num_q  <= AccW'(sum_sel[CW+CoordW-1] ? -sum_sel : sum_sel);
					den_q  <= AccW'(cnt_q);
					rem_q  <= '0;
					step_q <= '0;
				end
				ST_DIV, ST_VDIV: begin
					num_q  <= {num_q[AccW-2:0], 1'b0};
					step_q <= step_q + 7'd1;
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= AccW'(rem_sh - {1'b0, den_q});
						quo_q <= {quo_q[AccW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[AccW-1:0];
						quo_q <= {quo_q[AccW-2:0], 1'b0};
					end
					if (state_q == ST_DIV && step_q == 7'd63) begin
						if (axis_q) begin
							mean_y_q <= CoordW'(neg_q ? -(AccW'({quo_q[AccW-2:0], rem_sh >= {1'b0, den_q}}))
								: AccW'({quo_q[AccW-2:0], rem_sh >= {1'b0, den_q}}));
							idx_q <= '0;
							acc_x_q <= '0;
							acc_y_q <= '0;
						end else
							mean_x_q <= CoordW'(neg_q ? -(AccW'({quo_q[AccW-2:0], rem_sh >= {1'b0, den_q}}))
								: AccW'({quo_q[AccW-2:0], rem_sh >= {1'b0, den_q}}));
						axis_q <= ~axis_q;
					end
				end
				ST_DEV_WAIT: dev_q <= axis_q ? (CoordW+1)'($signed(rd_q[47:24])) - (CoordW+1)'(mean_y_q)
					: (CoordW+1)'($signed(rd_q[23:0])) - (CoordW+1)'(mean_x_q);
				ST_DEV_MUL: sq_q <= (2*CoordW+2)'(dev_sq);
				ST_DEV_ACC: begin
					if (axis_q) acc_y_q <= acc_y_q + AccW'(sq_q);
					else acc_x_q <= acc_x_q + AccW'(sq_q);
					if (axis_q) idx_q <= idx_q + AW'(1);
					axis_q <= ~axis_q;
					if (axis_q && !(CW'(idx_q) + CW'(1) < cnt_q)) begin
						std_x_q <= '0;
						std_y_q <= '0;
					end
				end
				ST_VDIV_INIT: begin
					num_q  <= acc_sel;
					den_q  <= AccW'(cnt_q - CW'(1));
					rem_q  <= '0;
					step_q <= '0;
				end
				ST_SQRT_INIT: begin
					num_q  <= quo_q;
					quo_q  <= '0;
					bit_q  <= {2'b01, {(AccW-2){1'b0}}};
					step_q <= '0;
				end
				ST_SQRT: begin
					step_q <= step_q + 7'd1;
					bit_q  <= bit_q >> 2;
					if (num_q >= sq_try) begin
						num_q <= num_q - sq_try;
						quo_q <= (quo_q >> 1) + bit_q;
					end else
						quo_q <= quo_q >> 1;
				end
				ST_NEXT_AXIS: begin
					if (axis_q) std_y_q <= quo_q[StdW-1:0];
					else std_x_q <= quo_q[StdW-1:0];
					axis_q <= ~axis_q;
				end
				ST_OUT: begin
					if (out_load) begin
						out_d_q <= {6'd0, std_y_q, std_x_q, mean_y_q, mean_x_q};
						out_u_q <= {ovf_q, cnt_q >= CW'(2)};
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						sum_x_q <= '0;
						sum_y_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !s_tready) else $error("point taken while busy");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS)) else $error("point count beyond capacity");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))) else $error("result dropped");
`endif
endmodule

FILE: test/point_mean_sample_stddev_unit_test.sv
// Testbench for the point mean and sample stddev unit: directed and random point sets.
module point_mean_sample_stddev_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned Cap = 1024;

	typedef struct packed {
		logic signed [23:0] mean_x;
		logic signed [23:0] mean_y;
		logic [24:0] std_x;
		logic [24:0] std_y;
		logic stddev_valid;
		logic overflowed;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic [1:0] m_tuser;

	point_mean_sample_stddev_unit #(.MAX_POINTS(Cap)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	bit abs_on;
	longint set_x[$];
	longint set_y[$];
	bit set_ovf;
	stats_t stats_q[$];

	int errors = 0;
	int results_seen = 0;
	int sets_sent = 0;
	int points_sent = 0;
	int hold_cycles = 0;
	bit rx_idle = 1'b1;

	function automatic longint coord_of(logic [23:0] raw);
		longint v;
		v = longint'($signed(raw));
		if (abs_on) begin
			if (v < 0) v = -v;
			if (v > 8388607) v = 8388607;
		end
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned a);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > a) b >>= 2;
		while (b != 0) begin
			if (a >= r + b) begin
				a -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void predict_point(logic [23:0] px, logic [23:0] py, bit last);
		longint sx, sy, mx, my, dx, dy, n;
		longint unsigned ax, ay;
		stats_t e;
		if (set_x.size() < Cap) begin
			set_x.push_back(coord_of(px));
			set_y.push_back(coord_of(py));
		end else begin
			set_ovf = 1'b1;
		end
		if (!last) return;
		n = set_x.size();
		sx = 0; sy = 0; ax = 0; ay = 0;
		foreach (set_x[i]) begin
			sx += set_x[i];
			sy += set_y[i];
		end
		mx = sx / n;
		my = sy / n;
		foreach (set_x[i]) begin
			dx = set_x[i] - mx;
			dy = set_y[i] - my;
			ax += longint'(dx * dx);
			ay += longint'(dy * dy);
		end
		e.mean_x = mx[23:0];
		e.mean_y = my[23:0];
		e.stddev_valid = n >= 2;
		e.std_x = e.stddev_valid ? 25'(int_sqrt(ax / longint'(n - 1))) : '0;
		e.std_y = e.stddev_valid ? 25'(int_sqrt(ay / longint'(n - 1))) : '0;
		e.overflowed = set_ovf;
		stats_q.push_back(e);
		set_x.delete();
		set_y.delete();
		set_ovf = 1'b0;
	endfunction

	// called at a falling edge; leaves valid up so back-to-back requests need no gap
	task automatic send_point(logic [23:0] px, logic [23:0] py, bit last, bit gaps = 1);
		int w;
		w = gaps ? $urandom_range(0, 17) : 0;
		if ($urandom_range(0, 3) == 0) w = 0;
		if (w > 0) begin
			s_tvalid <= 1'b0;
			repeat (w) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {py, px};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_point(px, py, last);
		points_sent++;
		if (last) sets_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (stats_q.size() != 0 && guard < 400000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(negedge clk);
	endtask

	task automatic write_abs(bit v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		abs_on = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'($urandom_range(0, 511)) - 24'd256;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_set(int n, bit gaps = 1);
		for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord(), i == n - 1, gaps);
	endtask

	task automatic test_directed();
		write_abs(1'b0);
		send_point(24'h000100, 24'hFFFF00, 1'b1);
		send_point(24'h7FFFFF, 24'h800000, 1'b0);
		send_point(24'h800000, 24'h7FFFFF, 1'b1);
		send_point(24'hFFFFFF, 24'h000001, 1'b0);
		send_point(24'h000002, 24'hFFFFFD, 1'b0);
		send_point(24'h000000, 24'h000000, 1'b1);
		drain();
		write_abs(1'b1);
		send_point(24'h800000, 24'h800000, 1'b0);
		send_point(24'h7FFFFF, 24'hFFFFFF, 1'b0);
		send_point(24'h800001, 24'h000005, 1'b1);
		send_point(24'hFFF000, 24'h001000, 1'b1);
		drain();
	endtask

	task automatic test_random();
		int n;
		for (int s = 0; s < 90; s++) begin
			if (s == 30 || s == 60) begin
				drain();
				write_abs($urandom_range(0, 1));
			end
			n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 14);
			send_set(n);
		end
		drain();
	endtask

	// one long set, then a long receiver hold-off while further sets keep coming
	task automatic test_stall();
		write_abs(1'b1);
		send_set(150);
		drain();
		write_abs(1'b0);
		hold_cycles = 3000;
		send_set(4, 1'b0);
		send_set(3, 1'b0);
		send_set(5, 1'b0);
		drain();
	endtask

	initial begin : receiver
		int w;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else if (rx_idle && $urandom_range(0, 3) == 0) begin
				w = $urandom_range(0, 17);
				if (w > 0) begin
					m_tready <= 1'b0;
					repeat (w) @(negedge clk);
				end
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		stats_t got, e;
		if (arst_n && m_tvalid && m_tready) begin
			got.mean_x = m_tdata[23:0];
			got.mean_y = m_tdata[47:24];
			got.std_x = m_tdata[72:48];
			got.std_y = m_tdata[97:73];
			got.stddev_valid = m_tuser[0];
			got.overflowed = m_tuser[1];
			results_seen++;
			if (stats_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
			end else begin
				e = stats_q.pop_front();
				if (got !== e) begin
					errors++;
					if (errors <= 10) $display("mismatch: expected %p actual %p", e, got);
				end
			end
		end
	end

	initial begin
		#100ms;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);
		test_directed();
		test_random();
		test_stall();
		drain();
		if (stats_q.size() != 0) errors++;
		$display("ran %0d sets, %0d points, %0d results checked", sets_sent, points_sent,
			results_seen);
		$display("covered abs on and off, single-point sets, a long set and a long output stall");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

FILE: filelist.f
rtl/pmsd_pkg.sv
rtl/point_mean_sample_stddev_unit.sv
test/point_mean_sample_stddev_unit_test.sv
